// File: sv/ktsel_pkg.sv
// Package for the streaming k-th largest / k-th smallest selector.
// Holds the store depth, field widths and the link record passed between cells.
// No dependencies.
package ktsel_pkg;

  localparam int unsigned MAX_K = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned K_W   = 6;
  localparam int unsigned CNT_W = $clog2(MAX_K + 1);
  localparam int unsigned IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  // What one cell hands to its right neighbor: its stored entries and
  // whether the incoming value ranks before them (or the entry is empty).
  typedef struct packed {
    logic signed [VAL_W-1:0] top_val;
    logic signed [VAL_W-1:0] bot_val;
    logic                    top_ins;
    logic                    bot_ins;
  } cell_link_t;

endpackage

// File: sv/ktsel_cell.sv
// One cell of the sorted chain: one entry of the descending top store and one
// entry of the ascending bottom store. Depends on ktsel_pkg.
module ktsel_cell (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [ktsel_pkg::VAL_W-1:0] value_i,
  input  ktsel_pkg::cell_link_t             link_i,
  output ktsel_pkg::cell_link_t             link_o
);
  import ktsel_pkg::*;

  logic signed [VAL_W-1:0] top_q, top_d;
  logic signed [VAL_W-1:0] bot_q, bot_d;
  logic                    top_ins, bot_ins;

  // Compare the new value against the held entries; an empty cell takes it
  assign top_ins = !valid_i || (value_i > top_q);
  assign bot_ins = !valid_i || (value_i < bot_q);

  // Shift in from the left neighbor, take the value, or hold
  always_comb begin
    if (link_i.top_ins) begin
      top_d = link_i.top_val;
    end else if (top_ins) begin
      top_d = value_i;
    end else begin
      top_d = top_q;
    end
    if (link_i.bot_ins) begin
      bot_d = link_i.bot_val;
    end else if (bot_ins) begin
      bot_d = value_i;
    end else begin
      bot_d = bot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

  assign link_o.top_val = top_q;
  assign link_o.bot_val = bot_q;
  assign link_o.top_ins = top_ins;
  assign link_o.bot_ins = bot_ins;

endmodule

// File: sv/ktsel_chain.sv
// Row of MAX_K sorting cells plus the read select of the chosen rank.
// Depends on ktsel_pkg and ktsel_cell.
module ktsel_chain (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [ktsel_pkg::CNT_W-1:0]        fill_i,
  input  logic signed [ktsel_pkg::VAL_W-1:0] value_i,
  input  logic [ktsel_pkg::IDX_W-1:0]        pick_i,
  output logic signed [ktsel_pkg::VAL_W-1:0] kth_largest_o,
  output logic signed [ktsel_pkg::VAL_W-1:0] kth_smallest_o
);
  import ktsel_pkg::*;

  cell_link_t              link [MAX_K+1];
  logic signed [VAL_W-1:0] top_vals [MAX_K];
  logic signed [VAL_W-1:0] bot_vals [MAX_K];

  // Nothing shifts into the head cell
  assign link[0] = '0;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    ktsel_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .valid_i (CNT_W'(i) < fill_i),
      .value_i (value_i),
      .link_i  (link[i]),
      .link_o  (link[i+1])
    );
    assign top_vals[i] = link[i+1].top_val;
    assign bot_vals[i] = link[i+1].bot_val;
  end

  // Select the entry at the requested rank
  assign kth_largest_o  = top_vals[pick_i];
  assign kth_smallest_o = bot_vals[pick_i];

endmodule

// File: sv/kth_largest_smallest_select.sv
// Top level of the streaming k-th largest / k-th smallest selector.
// Depends on ktsel_pkg and ktsel_chain.
//
//  channel  | direction | tdata (low bit up)                   | tuser      | tlast
//  s_axis   | in        | value[31:0]                          | -          | is_last
//  m_axis   | out       | kth_largest[31:0], kth_smallest[63:32]| short_set | -
//  cfg      | in        | rank_k[5:0]                          | -          | -
//
// Intake: one value is taken every cycle while no finished set waits for the
// output register. The cells insert a set's last value at the accepting edge,
// which also registers the rank pick; the chosen cell is then read into the
// output register as soon as that register is free.
// Reset clears the fill count, the pending set, the rank (to 1) and the output valid.
// A stalled output holds intake only while a finished set waits for the
// output register.
module kth_largest_smallest_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // value[31:0]
  input  logic [31:0]                   s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // kth_largest[31:0], kth_smallest[63:32]
  output logic [63:0]                   m_axis_tdata_o,
  // short_set[0]
  output logic [0:0]                    m_axis_tuser_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic [ktsel_pkg::K_W-1:0]     cfg_data_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o
);
  import ktsel_pkg::*;

  logic [K_W-1:0]          rank_q;
  logic [CNT_W-1:0]        fill_q, fill_d, fill_inc;
  logic                    pend_q;
  logic [IDX_W-1:0]        pick_q, pick_d;
  logic                    short_q, short_d;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_large_q, out_small_q;
  logic                    out_short_q;
  logic [CNT_W-1:0]        k_eff, pick_cnt;
  logic signed [VAL_W-1:0] chain_large, chain_small;
  logic                    in_xfer, can_load, load;

  assign can_load        = !out_valid_q || m_axis_tready_i;
  assign load            = pend_q && can_load;
  assign s_axis_tready_o = !pend_q || can_load;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Clamp the rank to 1..MAX_K
  always_comb begin
    if (rank_q == '0) begin
      k_eff = CNT_W'(1);
    end else if (CNT_W'(rank_q) > CNT_W'(MAX_K)) begin
      k_eff = CNT_W'(MAX_K);
    end else begin
      k_eff = CNT_W'(rank_q);
    end
  end

  // Count after this value, saturated at the store depth
  assign fill_inc = (fill_q == CNT_W'(MAX_K)) ? fill_q : fill_q + CNT_W'(1);
  assign fill_d   = s_axis_tlast_i ? '0 : fill_inc;
  assign short_d  = fill_inc < k_eff;
  assign pick_cnt = (short_d ? fill_inc : k_eff) - CNT_W'(1);
  assign pick_d   = pick_cnt[IDX_W-1:0];

  ktsel_chain u_chain (
    .clk_i          (clk_i),
    .en_i           (in_xfer),
    .fill_i         (fill_q),
    .value_i        (s_axis_tdata_i),
    .pick_i         (pick_q),
    .kth_largest_o  (chain_large),
    .kth_smallest_o (chain_small)
  );

  // Control: rank, fill count, pending set, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q      <= K_W'(1);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rank_q <= cfg_data_i;
      end
      if (in_xfer) begin
        fill_q <= fill_d;
      end
      if (in_xfer && s_axis_tlast_i) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: rank pick of the closing set, then the output register
  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast_i) begin
      pick_q  <= pick_d;
      short_q <= short_d;
    end
    if (load) begin
      out_large_q <= chain_large;
      out_small_q <= chain_small;
      out_short_q <= short_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_small_q, out_large_q};
  assign m_axis_tuser_o  = out_short_q;

endmodule

// File: tb/kth_largest_smallest_select_tb.sv
`timescale 1ns / 100ps
// Testbench for kth_largest_smallest_select: streams sets of signed values, predicts
// the k-th largest / k-th smallest of every set and checks each output transfer.
// Depends on ktsel_pkg and the selector RTL.
module kth_largest_smallest_select_tb;
  import ktsel_pkg::*;

  localparam int DEPTH        = MAX_K;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int PHASE_COUNT  = 10;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 10;
  localparam logic [31:0] EDGE_VALS [4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};

  // One result of a set: largest, smallest and the short-set flag
  typedef struct packed {
    logic [31:0] largest;
    logic [31:0] smallest;
    logic        short_set;
  } pick_t;

  typedef enum logic {ROW_VALUE, ROW_RANK} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] data;
    logic        last;
    bit          typed;
    pick_t       want;
  } row_t;

  typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic [31:0]      s_axis_tdata_i  = '0;
  logic             s_axis_tlast_i  = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [63:0]      m_axis_tdata_o;
  logic [0:0]       m_axis_tuser_o;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [K_W-1:0]   cfg_data_i      = '0;
  logic             cfg_valid_i     = 1'b0;
  logic             cfg_ready_o;

  kth_largest_smallest_select dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_data_i      (cfg_data_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: the largest values descending, the smallest ascending
  int             top_vals[$];
  int             bot_vals[$];
  int             set_fill = 0;
  logic [K_W-1:0] sel_rank = 1;
  pick_t          pending_picks[$];
  row_t           plan[$];

  int         items_sent    = 0;
  int         sets_sent     = 0;
  int         results_seen  = 0;
  int         mismatches    = 0;
  int         cycle_count   = 0;
  int         burst_left    = 0;
  int         gap_max       = 0;
  int         hold_left     = 0;
  int         stall_step    = 0;
  bit         long_hold_req = 1'b0;
  sink_mode_e sink_mode     = SINK_ALWAYS;
  logic [7:0] sink_pattern  = 8'b1011_0110;

  // Fold one value into the stores; return 1 with the pick when the set closes
  function automatic bit absorb_value(input logic [31:0] raw, input logic last,
                                      output pick_t pick);
    int v;
    int i;
    int k;
    int idx;
    v    = raw;
    pick = '0;
    i    = 0;
    while (i < top_vals.size() && top_vals[i] >= v) i++;
    if (i < DEPTH) top_vals.insert(i, v);
    if (top_vals.size() > DEPTH) void'(top_vals.pop_back());
    i = 0;
    while (i < bot_vals.size() && bot_vals[i] <= v) i++;
    if (i < DEPTH) bot_vals.insert(i, v);
    if (bot_vals.size() > DEPTH) void'(bot_vals.pop_back());
    if (set_fill < DEPTH) set_fill++;
    if (!last) return 1'b0;
    // Clamp the rank into 1..MAX_K
    k = sel_rank;
    if (k < 1) k = 1;
    if (k > DEPTH) k = DEPTH;
    idx            = (set_fill < k) ? set_fill : k;
    pick.largest   = top_vals[idx-1];
    pick.smallest  = bot_vals[idx-1];
    pick.short_set = (set_fill < k);
    top_vals.delete();
    bot_vals.delete();
    set_fill = 0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 7) return $urandom_range(0, 16) - 8;
    if (sel < 8) return EDGE_VALS[$urandom_range(0, 3)];
    if (sel < 9) return 32'h7fffffff - $urandom_range(0, 3);
    return 32'h80000000 + $urandom_range(0, 3);
  endfunction

  // Mostly short sets, some past the store depth
  function automatic int set_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(1, 8);
    if (sel < 8) return $urandom_range(9, 40);
    return $urandom_range(30, 80);
  endfunction

  function automatic void add_value(input logic [31:0] v, input logic last);
    row_t row;
    row = '{ROW_VALUE, v, last, 1'b0, '0};
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_checked(input logic [31:0] v, input logic last,
                                      input logic [31:0] lg, input logic [31:0] sm,
                                      input logic sh);
    row_t row;
    row = '{ROW_VALUE, v, last, 1'b1, '{lg, sm, sh}};
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_rank(input logic [K_W-1:0] r);
    row_t row;
    row = '{ROW_RANK, 32'(r), 1'b0, 1'b0, '0};
    plan.insert(plan.size(), row);
  endfunction

  // Offer one value, with a random gap at the end of each burst when gap_max is nonzero
  task automatic offer_value(input logic [31:0] v, input logic last, input bit typed,
                             input pick_t want);
    pick_t got;
    if (gap_max > 0 && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= last;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left > 0) burst_left--;
    items_sent++;
    if (absorb_value(v, last, got)) begin
      pending_picks.insert(pending_picks.size(), typed ? want : got);
      sets_sent++;
    end
  endtask

  // Stop offering until every pending result has been taken
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rank(input logic [K_W-1:0] r);
    wait_drained();
    cfg_data_i  <= r;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sel_rank = r;
  endtask

  task automatic report_mismatch(input string what, input pick_t want, input pick_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s: expected lg=%0d sm=%0d short=%0b, got lg=%0d sm=%0d short=%0b",
               $realtime, what, $signed(want.largest), $signed(want.smallest), want.short_set,
               $signed(seen.largest), $signed(seen.smallest), seen.short_set);
  endtask

  // Receiver: stall pattern per phase, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_ALWAYS: m_axis_tready_i <= 1'b1;
        SINK_RANDOM: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        default:     m_axis_tready_i <= sink_pattern[stall_step % 8];
      endcase
    end
    stall_step++;
  end

  // Check each output transfer against the oldest pending pick
  always @(posedge clk_i) begin
    pick_t seen;
    pick_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen = '{m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tuser_o[0]};
      results_seen++;
      if (pending_picks.size() == 0) begin
        report_mismatch("result with nothing pending", '0, seen);
      end else begin
        want = pending_picks.pop_front();
        if (seen.largest !== want.largest || seen.smallest !== want.smallest ||
            seen.short_set !== want.short_set)
          report_mismatch("result mismatch", want, seen);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               pending_picks.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned rank_plan [PHASE_COUNT];
    int          phase_items;
    int          len;
    bit          pressure;

    // Directed sets: extremes, short sets, equal values, clamped and mid-set ranks
    add_checked(32'd5, 1'b1, 32'd5, 32'd5, 1'b0);
    add_value(32'h7fffffff, 1'b0);
    add_checked(32'h80000000, 1'b1, 32'h7fffffff, 32'h80000000, 1'b0);
    add_value(32'h80000000, 1'b0);
    add_value(32'h0, 1'b0);
    add_value(32'hffffffff, 1'b0);
    add_value(32'h1, 1'b1);
    add_rank(6'd3);
    add_checked(32'd7, 1'b1, 32'd7, 32'd7, 1'b1);
    add_value(32'd10, 1'b0);
    add_checked(32'd20, 1'b1, 32'd10, 32'd20, 1'b1);
    add_value(32'd4, 1'b0);
    add_value(32'd4, 1'b0);
    add_value(32'd4, 1'b0);
    add_value(32'd9, 1'b1);
    add_rank(6'd0);
    add_value(32'hfffffffd, 1'b0);
    add_checked(32'd8, 1'b1, 32'd8, 32'hfffffffd, 1'b0);
    add_rank(6'd63);
    add_checked(32'd1, 1'b1, 32'd1, 32'd1, 1'b1);
    add_rank(6'd1);
    add_value(32'd3, 1'b0);
    add_value(32'd1, 1'b0);
    add_rank(6'd2);
    add_value(32'd2, 1'b1);

    // Hold reset low, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_RANK) write_rank(plan[r].data[K_W-1:0]);
      else offer_value(plan[r].data, plan[r].last, plan[r].typed, plan[r].want);
    end

    // Random phases; the last one runs against a long output hold-off
    rank_plan = '{1, 32, 2, 31, 16, 5, $urandom_range(1, 32), $urandom_range(1, 32), 32, 2};
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_rank(rank_plan[p][K_W-1:0]);
      pressure    = (p == PHASE_COUNT - 1);
      sink_mode   = sink_mode_e'(p % 3);
      gap_max     = (pressure || p % 4 == 1) ? 0 : ((p % 4 == 2) ? 2 : 8);
      burst_left  = 0;
      phase_items = 0;
      if (pressure) long_hold_req = 1'b1;
      while (phase_items < RANDOM_ITEMS / PHASE_COUNT) begin
        len = pressure ? $urandom_range(1, 3) : set_length();
        // Trim the last set so the phase ends on its item budget
        if (len > RANDOM_ITEMS / PHASE_COUNT - phase_items)
          len = RANDOM_ITEMS / PHASE_COUNT - phase_items;
        for (int j = 0; j < len; j++)
          offer_value(pick_value(), j == len - 1, 1'b0, '0);
        phase_items += len;
      end
    end

    // Drain and let the pipeline settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += pending_picks.size();

    $display("Streamed %0d values in %0d sets, %0d results checked, ranks 0 to 63",
             items_sent, sets_sent, results_seen);
    $display("Output side ran free, random, patterned and through a %0d-cycle hold-off; %0d mismatches",
             LONG_HOLD, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ktsel_pkg.sv
sv/ktsel_cell.sv
sv/ktsel_chain.sv
sv/kth_largest_smallest_select.sv
tb/kth_largest_smallest_select_tb.sv
